// ===== sv/cmix_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmix_pkg
// Shared widths, constants and word types of the complex LO phase mixer.
// ----------------------------------------------------------------------------
package cmix_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int PRESHIFT        = 64 - 2 * SAMPLE_BITS;
    localparam int HALF_SHIFT      = PRESHIFT / 2;
    localparam int PROD_W          = 2 * SAMPLE_BITS;
    localparam int NUM_W           = PROD_W + HALF_SHIFT;
    localparam int QUO_W           = SAMPLE_BITS + 2;
    localparam int RAD_W           = PROD_W + PRESHIFT;
    localparam int ROOT_W          = RAD_W / 2;
    localparam int SQ_STEPS        = ROOT_W;
    localparam int CNT_W           = $clog2(SQ_STEPS);
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sig_re;
        logic signed [SAMPLE_BITS-1:0] sig_im;
        logic signed [SAMPLE_BITS-1:0] lo_re;
        logic signed [SAMPLE_BITS-1:0] lo_im;
        logic                          lo_fresh;
    } cmix_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_re;
        logic signed [SAMPLE_BITS-1:0] out_im;
        logic                          lo_zero;
        logic                          clipped;
    } cmix_out_t;

    // one queued word: signal and the LO it uses
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sig_re;
        logic signed [SAMPLE_BITS-1:0] sig_im;
        logic signed [SAMPLE_BITS-1:0] lo_re;
        logic signed [SAMPLE_BITS-1:0] lo_im;
        logic                          lo_zero;
    } cmix_entry_t;

endpackage
`default_nettype wire

// ===== sv/cmix_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmix_front
// Accepts input words, keeps the held LO and flags a zero LO.
// ----------------------------------------------------------------------------
module cmix_front import cmix_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire cmix_in_t    s_data,
    input  wire logic        q_full,
    output logic             q_push,
    output cmix_entry_t      q_data
);

    logic signed [SAMPLE_BITS-1:0] held_re_reg;
    logic signed [SAMPLE_BITS-1:0] held_im_reg;
    logic signed [SAMPLE_BITS-1:0] lo_re_use;
    logic signed [SAMPLE_BITS-1:0] lo_im_use;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    assign lo_re_use = s_data.lo_fresh ? s_data.lo_re : held_re_reg;
    assign lo_im_use = s_data.lo_fresh ? s_data.lo_im : held_im_reg;

    always_comb begin
        q_data.sig_re  = s_data.sig_re;
        q_data.sig_im  = s_data.sig_im;
        q_data.lo_re   = lo_re_use;
        q_data.lo_im   = lo_im_use;
        q_data.lo_zero = (lo_re_use == '0) && (lo_im_use == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_re_reg <= '0;
            held_im_reg <= '0;
        end else if (q_push && s_data.lo_fresh) begin
            held_re_reg <= s_data.lo_re;
            held_im_reg <= s_data.lo_im;
        end
    end

endmodule
`default_nettype wire

// ===== sv/cmix_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmix_fifo
// Short queue between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
module cmix_fifo import cmix_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire cmix_entry_t  push_data,
    input  wire logic         pop,
    output cmix_entry_t       pop_data,
    output logic              full,
    output logic              empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmix_entry_t        mem [DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg;
    logic [IDX_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

endmodule
`default_nettype wire

// ===== sv/cmix_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmix_back
// Rotates one queued word: products, LO magnitude by a two-bit-per-cycle
// square root, two restoring dividers, then rounding and saturation.
// ----------------------------------------------------------------------------
module cmix_back import cmix_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire cmix_entry_t  q_data,
    input  wire logic         q_empty,
    output logic              q_pop,
    output logic              m_valid,
    input  wire logic         m_ready,
    output cmix_out_t         m_data
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_PREP  = 7'b0000100,
        ST_SQRT  = 7'b0001000,
        ST_DINIT = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] val;
        logic                          clip;
    } part_t;

    localparam logic [QUO_W:0] LIM = (QUO_W + 1)'(1) << (SAMPLE_BITS - 1);

    // round-away remainder handled by caller; saturate magnitude q with sign
    function automatic part_t sat_part(input logic [QUO_W:0] q, input logic neg);
        part_t r;
        r.clip = 1'b0;
        if (neg) begin
            if (q >= LIM) begin
                r.val  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                r.clip = 1'b1;
            end else begin
                r.val = SAMPLE_BITS'(~q[SAMPLE_BITS-1:0] + 1'b1);
            end
        end else begin
            if (q >= LIM) begin
                r.val  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                r.clip = 1'b1;
            end else begin
                r.val = q[SAMPLE_BITS-1:0];
            end
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    logic   m_valid_reg;
    logic [CNT_W-1:0] cnt_reg;

    cmix_entry_t               entry_reg;
    logic signed [PROD_W-1:0]  prod_a_reg, prod_b_reg, prod_c_reg, prod_d_reg;
    logic [PROD_W-1:0]         sq_re_reg, sq_im_reg;
    logic [NUM_W-1:0]          num_re_reg, num_im_reg;
    logic                      neg_re_reg, neg_im_reg;
    logic [RAD_W-1:0]          rad_reg;
    logic [ROOT_W:0]           sqrem_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [ROOT_W-1:0]         drem_re_reg, drem_im_reg;
    logic [QUO_W-1:0]          quo_re_reg, quo_im_reg;
    cmix_out_t                 out_reg;

    logic signed [PROD_W:0]    diff_re, diff_im;
    logic [PROD_W-1:0]         mag_re, mag_im;
    logic [PROD_W-1:0]         m_sum;
    logic [ROOT_W+2:0]         sq_shift, sq_trial, sq_diff;
    logic                      sq_ge;
    logic [ROOT_W:0]           t_re, t_im, d_ext;
    logic                      ge_re, ge_im;
    logic [ROOT_W:0]           sub_re, sub_im;
    logic                      rup_re, rup_im;
    logic [QUO_W:0]            qr_re, qr_im;
    part_t                     p_re, p_im;
    logic                      out_free;
    logic                      fin_load;

    assign diff_re = {prod_a_reg[PROD_W-1], prod_a_reg} - {prod_b_reg[PROD_W-1], prod_b_reg};
    assign diff_im = {prod_c_reg[PROD_W-1], prod_c_reg} + {prod_d_reg[PROD_W-1], prod_d_reg};
    assign mag_re  = diff_re[PROD_W] ? PROD_W'(-diff_re) : diff_re[PROD_W-1:0];
    assign mag_im  = diff_im[PROD_W] ? PROD_W'(-diff_im) : diff_im[PROD_W-1:0];
    assign m_sum   = sq_re_reg + sq_im_reg;

    // square root digit: bring down two radicand bits, try 4*root+1
    assign sq_shift = {sqrem_reg, rad_reg[RAD_W-1 -: 2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = (sq_shift >= sq_trial);
    assign sq_diff  = sq_shift - sq_trial;

    // restoring divide, one quotient bit per cycle for each part
    assign d_ext  = {1'b0, root_reg};
    assign t_re   = {drem_re_reg, quo_re_reg[QUO_W-1]};
    assign t_im   = {drem_im_reg, quo_im_reg[QUO_W-1]};
    assign ge_re  = (t_re >= d_ext);
    assign ge_im  = (t_im >= d_ext);
    assign sub_re = t_re - d_ext;
    assign sub_im = t_im - d_ext;

    // round to nearest, ties away from zero
    assign rup_re = ({drem_re_reg, 1'b0} >= d_ext);
    assign rup_im = ({drem_im_reg, 1'b0} >= d_ext);
    assign qr_re  = {1'b0, quo_re_reg} + (QUO_W + 1)'(rup_re);
    assign qr_im  = {1'b0, quo_im_reg} + (QUO_W + 1)'(rup_im);
    assign p_re   = sat_part(qr_re, neg_re_reg);
    assign p_im   = sat_part(qr_im, neg_im_reg);

    assign out_free = !m_valid_reg || m_ready;
    assign fin_load = (state_reg == ST_FIN) && out_free;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (!q_empty) state_next = ST_MUL;
            ST_MUL:   state_next = ST_PREP;
            ST_PREP:  state_next = entry_reg.lo_zero ? ST_FIN : ST_SQRT;
            ST_SQRT:  if (cnt_reg == CNT_W'(SQ_STEPS - 1)) state_next = ST_DINIT;
            ST_DINIT: state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == CNT_W'(QUO_W - 1)) state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (fin_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_SQRT || state_reg == ST_DIV) begin
                cnt_reg <= (state_next == state_reg) ? cnt_reg + 1'b1 : '0;
            end else begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    entry_reg <= q_data;
                end
            end
            ST_MUL: begin
                prod_a_reg <= $signed(entry_reg.sig_re) * $signed(entry_reg.lo_re);
                prod_b_reg <= $signed(entry_reg.sig_im) * $signed(entry_reg.lo_im);
                prod_c_reg <= $signed(entry_reg.sig_re) * $signed(entry_reg.lo_im);
                prod_d_reg <= $signed(entry_reg.sig_im) * $signed(entry_reg.lo_re);
                sq_re_reg  <= PROD_W'($signed(entry_reg.lo_re) * $signed(entry_reg.lo_re));
                sq_im_reg  <= PROD_W'($signed(entry_reg.lo_im) * $signed(entry_reg.lo_im));
            end
            ST_PREP: begin
                num_re_reg <= {mag_re, {HALF_SHIFT{1'b0}}};
                num_im_reg <= {mag_im, {HALF_SHIFT{1'b0}}};
                neg_re_reg <= diff_re[PROD_W];
                neg_im_reg <= diff_im[PROD_W];
                rad_reg    <= {m_sum, {PRESHIFT{1'b0}}};
                sqrem_reg  <= '0;
                root_reg   <= '0;
            end
            ST_SQRT: begin
                sqrem_reg <= sq_ge ? sq_diff[ROOT_W:0] : sq_shift[ROOT_W:0];
                root_reg  <= {root_reg[ROOT_W-2:0], sq_ge};
                rad_reg   <= {rad_reg[RAD_W-3:0], 2'b00};
            end
            ST_DINIT: begin
                drem_re_reg <= ROOT_W'(num_re_reg[NUM_W-1:QUO_W]);
                drem_im_reg <= ROOT_W'(num_im_reg[NUM_W-1:QUO_W]);
                quo_re_reg  <= num_re_reg[QUO_W-1:0];
                quo_im_reg  <= num_im_reg[QUO_W-1:0];
            end
            ST_DIV: begin
                drem_re_reg <= ge_re ? sub_re[ROOT_W-1:0] : t_re[ROOT_W-1:0];
                drem_im_reg <= ge_im ? sub_im[ROOT_W-1:0] : t_im[ROOT_W-1:0];
                quo_re_reg  <= {quo_re_reg[QUO_W-2:0], ge_re};
                quo_im_reg  <= {quo_im_reg[QUO_W-2:0], ge_im};
            end
            ST_FIN: begin
                if (out_free) begin
                    if (entry_reg.lo_zero) begin
                        out_reg.out_re  <= '0;
                        out_reg.out_im  <= '0;
                        out_reg.lo_zero <= 1'b1;
                        out_reg.clipped <= 1'b0;
                    end else begin
                        out_reg.out_re  <= p_re.val;
                        out_reg.out_im  <= p_im.val;
                        out_reg.lo_zero <= 1'b0;
                        out_reg.clipped <= p_re.clip || p_im.clip;
                    end
                end
            end
            default: ;
        endcase
    end

    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (drem_re_reg < root_reg) && (drem_im_reg < root_reg))
        else $error("divider remainder not below magnitude");

    a_fin_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_load |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("finished word not presented");

endmodule
`default_nettype wire

// ===== sv/complex_lo_phase_mixer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_lo_phase_mixer
// Rotates a complex Q1.15 sample by the angle of a held or fresh LO sample.
//
//   channel  dir  handshake          word
//   s_       in   s_valid/s_ready    cmix_in_t  (signal, LO, lo_fresh)
//   m_       out  m_valid/m_ready    cmix_out_t (rotated sample, flags)
//
// A word with a nonzero LO passes the back end through pop, multiply,
// prepare, the square-root digit steps, divider load, the divide steps, finish.
// The square root and divider iterations take most of the time; a word with a
// zero LO skips both: pop, multiply, prepare, finish.
// The front takes words into the queue while the back end works, until full.
// A full output register holds the back end in its finish cycle.
// Reset (aresetn, synchronous) clears the held LO to zero.
// ----------------------------------------------------------------------------
module complex_lo_phase_mixer import cmix_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire cmix_in_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output cmix_out_t       m_data
);

    cmix_entry_t push_data;
    cmix_entry_t pop_data;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;

    cmix_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (full),
        .q_push  (push),
        .q_data  (push_data)
    );

    cmix_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    cmix_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_data  (pop_data),
        .q_empty (empty),
        .q_pop   (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
